// ===== hdl/npcs_pkg.sv =====
// Shared types and constants for the nearest palette color search block.
package npcs_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned CFG_W             = 9;
  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned IDX_W             = 8;
  localparam int unsigned COLOR_W           = 3 * CHAN_W;
  localparam int unsigned SQ_W              = 2 * CHAN_W;
  localparam int unsigned DIST_W            = 18;
  localparam logic [DIST_W-1:0] DIST_START  = DIST_W'(3 * 256 * 256);
  localparam logic [CFG_W-1:0]  SIZE_RESET  = CFG_W'(256);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MAP  = 1'b1;

  typedef struct packed {
    logic              is_map;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } cmd_t;

  function automatic logic [SQ_W-1:0] chan_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// ===== hdl/nearest_palette_color_search.sv =====
// Throughput: one load word per cycle while the back end is idle and the queue has room;
// map words are searched one at a time, each search paced by the single palette RAM read
//   port, which serves one entry per cycle.
// The two-word front queue keeps taking words, until full, while a search runs or a result waits.
// Reset (rst_ni low, async) empties the queue and result, sets palette_size to 256;
//   palette contents are not cleared and stay undefined until loaded.
module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input word queue
  input  logic              push_i,
  output logic              full_o,
  input  logic              mode_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  // result word register
  output logic              empty_o,
  input  logic              pop_i,
  output logic [IDX_W-1:0]  color_index_o,
  // palette_size register
  input  logic              palette_size_we_i,
  input  logic [CFG_W-1:0]  palette_size_i
);

  logic [CFG_W-1:0] palette_size_q;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;

  // Search length register; values above the depth are clamped in the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= SIZE_RESET;
    end else if (palette_size_we_i) begin
      palette_size_q <= palette_size_i;
    end
  end

  // Front: decode mode, drop out-of-range loads, buffer two words.
  npcs_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .mode_i        (mode_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Back: loads write the palette RAM; maps stream entries through a
  // read / square / sum-compare pipeline, earliest minimum wins.
  npcs_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .palette_size_i (palette_size_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .color_index_o  (color_index_o)
  );

endmodule

// ===== hdl/npcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module npcs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/npcs_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
module npcs_front import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              mode_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  localparam int unsigned QD = 2;

  cmd_t       buf_q [QD];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, keep, enq, deq;
  cmd_t       cmd_new;

  assign full_o      = (cnt_q == 2'(QD));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign accept      = push_i && !full_o;

  // loads past the palette depth are dropped here
  always_comb begin
    cmd_new.is_map      = (mode_i == MODE_MAP);
    cmd_new.entry_index = entry_index_i;
    cmd_new.red         = red_i;
    cmd_new.green       = green_i;
    cmd_new.blue        = blue_i;
    keep = cmd_new.is_map || ({1'b0, entry_index_i} < (IDX_W + 1)'(PALETTE_DEPTH));
  end

  assign enq = accept && keep;
  assign deq = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 2'd1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      buf_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/npcs_back.sv =====
// Back end: palette store, distance search pipeline and result register.
module npcs_back import npcs_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(PALETTE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] palette_size_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [IDX_W-1:0] color_index_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CFG_W-1:0]   k_q, size_q, size_eff;
  logic [COLOR_W-1:0] pix_q, rdata;
  logic               v1_q, v2_q, issue;
  logic [AW-1:0]      idx1_q, idx2_q, best_q;
  logic [SQ_W-1:0]    sqr_q, sqg_q, sqb_q;
  logic [DIST_W-1:0]  cur_dist, best_dist_q;
  logic               better, ram_we, out_room;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_q;

  assign size_eff = (palette_size_i > CFG_W'(PALETTE_DEPTH)) ?
                    CFG_W'(PALETTE_DEPTH) : palette_size_i;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_we    = cmd_pop_o && !cmd_i.is_map;
  assign issue     = (state_q == ST_ISSUE);
  assign out_room  = !out_valid_q || pop_i;

  npcs_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.entry_index[AW-1:0]),
    .wdata_i ({cmd_i.red, cmd_i.green, cmd_i.blue}),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign cur_dist = DIST_W'(sqr_q) + DIST_W'(sqg_q) + DIST_W'(sqb_q);
  assign better   = v2_q && (cur_dist < best_dist_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.is_map) begin
          state_d = (size_eff == '0) ? ST_RESULT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == size_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_room) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (state_q == ST_RESULT && out_room) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.is_map) begin
      pix_q       <= {cmd_i.red, cmd_i.green, cmd_i.blue};
      size_q      <= size_eff;
      k_q         <= '0;
      best_q      <= '0;
      best_dist_q <= DIST_START;
    end else begin
      if (issue) begin
        k_q <= k_q + 1'b1;
      end
      if (better) begin
        best_q      <= idx2_q;
        best_dist_q <= cur_dist;
      end
    end
    idx1_q <= k_q[AW-1:0];
    idx2_q <= idx1_q;
    sqr_q  <= chan_sq(rdata[23:16], pix_q[23:16]);
    sqg_q  <= chan_sq(rdata[15:8],  pix_q[15:8]);
    sqb_q  <= chan_sq(rdata[7:0],   pix_q[7:0]);
    if (state_q == ST_RESULT && out_room) begin
      out_q <= IDX_W'(best_q);
    end
  end

  assign empty_o       = !out_valid_q;
  assign color_index_o = out_q;

`ifndef SYNTHESIS
  a_load_not_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !v1_q && !v2_q)
    else $error("palette write during a search");
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> k_q < size_q)
    else $error("search address beyond palette size");
  a_result_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> !v1_q && !v2_q)
    else $error("result taken before search pipeline drained");
  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("compare stage without read stage");
`endif

endmodule
